// ===== hw/rtl/lpc_pkg.sv =====
// ---------------------------------------------------------------------------
// lpc_pkg
// Shared types for the LRU page cache: transfer payloads and control bundle.
// ---------------------------------------------------------------------------
package lpc_pkg;

  localparam int CFG_BITS    = 7;
  localparam int CNT_BITS    = 32;
  localparam int NUM_CNT     = 8;
  localparam logic [CFG_BITS-1:0] CAP_RESET = 7'd64;

  localparam int CNT_HIT      = 0;
  localparam int CNT_REQ      = 1;
  localparam int CNT_WB_ADMIT = 2;
  localparam int CNT_WB_EVICT = 3;
  localparam int CNT_WT_ADMIT = 4;
  localparam int CNT_WT_EVICT = 5;
  localparam int CNT_RD       = 6;
  localparam int CNT_WR       = 7;

  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic [31:0] page_number;
    logic        mode;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic        evicted_valid;
    logic [31:0] evicted_page;
    logic        evicted_dirty;
    logic [31:0] hit_total;
    logic [31:0] request_total;
    logic [31:0] wb_admit_total;
    logic [31:0] wb_evict_total;
    logic [31:0] wt_admit_total;
    logic [31:0] wt_evict_total;
    logic [31:0] cache_read_total;
    logic [31:0] cache_write_total;
  } out_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic update;
  } cmd_t;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v,
                                                  input logic en);
    sat_inc = (en && (v != {CNT_BITS{1'b1}})) ? v + 1'b1 : v;
  endfunction

endpackage

// ===== hw/rtl/lpc_ctrl.sv =====
// ---------------------------------------------------------------------------
// lpc_ctrl
// Sequencer: capture, lookup, update; one access in flight at a time.
// ---------------------------------------------------------------------------
module lpc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output lpc_pkg::cmd_t cmd
);
  import lpc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOOKUP, S_UPDATE} state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_LOOKUP;
            busy  <= 1'b1;
          end
        end
        S_LOOKUP: state <= S_UPDATE;
        S_UPDATE: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  assign cmd.load   = (state == S_IDLE) && start && !busy;
  assign cmd.lookup = (state == S_LOOKUP);
  assign cmd.update = (state == S_UPDATE);

endmodule

// ===== hw/rtl/lpc_datapath.sv =====
// ---------------------------------------------------------------------------
// lpc_datapath
// Entry lanes with parallel tag compare, recency ranks, dirty bits, counters.
// ---------------------------------------------------------------------------
module lpc_datapath #(
  parameter int CAPACITY  = 64,
  parameter int PAGE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lpc_pkg::cmd_t                 cmd,
  input  lpc_pkg::in_t                  item,
  input  logic                          cfg_we,
  input  logic [lpc_pkg::CFG_BITS-1:0]  cfg_data,
  output lpc_pkg::out_t                 result,
  output logic                          done
);
  import lpc_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int CW = (OW > CFG_BITS) ? OW : CFG_BITS;
  localparam logic [CW-1:0] CAP_MAX = CW'(CAPACITY);

  logic [PAGE_BITS-1:0] entry_page [CAPACITY];
  logic [CAPACITY-1:0]  entry_valid;
  logic [CAPACITY-1:0]  entry_dirty;
  logic [AW-1:0]        entry_age  [CAPACITY];
  logic [OW-1:0]        occupancy;
  logic [CNT_BITS-1:0]  cnt [NUM_CNT];
  logic [CFG_BITS-1:0]  cap;

  logic [PAGE_BITS-1:0] req_page;
  logic                 req_rd;
  logic [CAPACITY-1:0]  hit_vec, victim_vec, free_vec;
  logic [AW-1:0]        hit_age;
  logic                 full;

  logic [CW-1:0]        cap_ext, cap_eff;
  logic [CAPACITY-1:0]  hit_vec_next, victim_vec_next, free_vec_next;
  logic [AW-1:0]        hit_age_next;
  logic [AW-1:0]        lru_age;
  logic [63:0]          pn_ext;
  logic [63:0]          ev_page_ext;
  logic [PAGE_BITS-1:0] ev_page;
  logic                 ev_dirty;
  logic                 hit;
  logic [CNT_BITS-1:0]  cnt_next [NUM_CNT];

  assign cap_ext = CW'(cap);
  always_comb begin
    cap_eff = cap_ext;
    if (cap_ext == '0) cap_eff = CW'(1);
    if (cap_ext > CAP_MAX) cap_eff = CAP_MAX;
  end

  assign lru_age = AW'(occupancy - 1'b1);
  assign pn_ext  = {32'b0, item.page_number};

  always_comb begin
    hit_age_next = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec_next[i]    = entry_valid[i] && (entry_page[i] == req_page);
      victim_vec_next[i] = entry_valid[i] && (entry_age[i] == lru_age);
      if (hit_vec_next[i]) hit_age_next = hit_age_next | entry_age[i];
    end
    free_vec_next = ~entry_valid & (entry_valid + 1'b1);
  end

  always_comb begin
    ev_page  = '0;
    ev_dirty = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (victim_vec[i]) begin
        ev_page  = ev_page | entry_page[i];
        ev_dirty = ev_dirty | entry_dirty[i];
      end
    end
    if (!full || hit) begin
      ev_page  = '0;
      ev_dirty = 1'b0;
    end
  end

  assign hit         = |hit_vec;
  assign ev_page_ext = 64'(ev_page);

  always_comb begin
    for (int k = 0; k < NUM_CNT; k++) cnt_next[k] = cnt[k];
    cnt_next[CNT_REQ]      = sat_inc(cnt[CNT_REQ], 1'b1);
    cnt_next[CNT_WR]       = sat_inc(cnt[CNT_WR], !req_rd);
    cnt_next[CNT_WT_EVICT] = sat_inc(cnt[CNT_WT_EVICT], !req_rd);
    cnt_next[CNT_HIT]      = sat_inc(cnt[CNT_HIT], hit);
    cnt_next[CNT_RD]       = sat_inc(cnt[CNT_RD], hit && req_rd);
    cnt_next[CNT_WB_EVICT] = sat_inc(cnt[CNT_WB_EVICT], ev_dirty);
    cnt_next[CNT_WB_ADMIT] = sat_inc(cnt[CNT_WB_ADMIT], !hit && req_rd);
    cnt_next[CNT_WT_ADMIT] = sat_inc(cnt[CNT_WT_ADMIT], !hit && req_rd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_page <= pn_ext[PAGE_BITS-1:0];
      req_rd   <= (item.mode == MODE_READ);
    end
    if (cmd.lookup) begin
      hit_vec    <= hit_vec_next;
      victim_vec <= victim_vec_next;
      free_vec   <= free_vec_next;
      hit_age    <= hit_age_next;
      full       <= (CW'(occupancy) >= cap_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_dirty <= '0;
      occupancy   <= '0;
      done        <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) entry_age[i] <= '0;
      for (int k = 0; k < NUM_CNT; k++) cnt[k] <= '0;
    end else begin
      done <= cmd.update;
      if (cmd.update) begin
        for (int k = 0; k < NUM_CNT; k++) cnt[k] <= cnt_next[k];
        if (hit) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (hit_vec[i]) begin
              entry_age[i] <= '0;
              if (!req_rd) entry_dirty[i] <= 1'b1;
            end else if (entry_valid[i] && entry_age[i] < hit_age) begin
              entry_age[i] <= entry_age[i] + 1'b1;
            end
          end
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (full ? victim_vec[i] : free_vec[i]) begin
              entry_page[i]  <= req_page;
              entry_valid[i] <= 1'b1;
              entry_dirty[i] <= !req_rd;
              entry_age[i]   <= '0;
            end else if (entry_valid[i]) begin
              entry_age[i] <= entry_age[i] + 1'b1;
            end
          end
          if (!full) occupancy <= occupancy + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      result.hit               <= hit;
      result.evicted_valid     <= full && !hit;
      result.evicted_page      <= ev_page_ext[31:0];
      result.evicted_dirty     <= ev_dirty;
      result.hit_total         <= cnt_next[CNT_HIT];
      result.request_total     <= cnt_next[CNT_REQ];
      result.wb_admit_total    <= cnt_next[CNT_WB_ADMIT];
      result.wb_evict_total    <= cnt_next[CNT_WB_EVICT];
      result.wt_admit_total    <= cnt_next[CNT_WT_ADMIT];
      result.wt_evict_total    <= cnt_next[CNT_WT_EVICT];
      result.cache_read_total  <= cnt_next[CNT_RD];
      result.cache_write_total <= cnt_next[CNT_WR];
    end
  end

endmodule

// ===== hw/rtl/lru_page_cache_with_dirty_tracking.sv =====
// ---------------------------------------------------------------------------
// lru_page_cache_with_dirty_tracking
// Fully associative LRU page cache with dirty tracking and I/O counters.
// ---------------------------------------------------------------------------
// An access is taken when start is high and busy is low. Its result appears
// on result with done high for one cycle, registered at the end of the
// update state; the receiver cannot stall it. busy stays high for the whole
// access: through the lookup state for the parallel tag compare and victim
// search over all entry lanes, and through the update state for the rank,
// dirty and counter update. A new access may be started in the cycle done is
// shown. cfg_we writes cache_capacity.
module lru_page_cache_with_dirty_tracking #(
  parameter int CAPACITY  = 64,
  parameter int PAGE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  lpc_pkg::in_t                  item,
  output lpc_pkg::out_t                 result,
  output logic                          done,
  input  logic                          cfg_we,
  input  logic [lpc_pkg::CFG_BITS-1:0]  cfg_data
);
  import lpc_pkg::*;

  cmd_t cmd;

  lpc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  lpc_datapath #(
    .CAPACITY  (CAPACITY),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .result   (result),
    .done     (done)
  );

endmodule

// ===== hw/rtl/lpc_checker.sv =====
// ---------------------------------------------------------------------------
// lpc_port_checks
// Port-level checks on access timing and result consistency.
// ---------------------------------------------------------------------------
module lpc_port_checks (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input lpc_pkg::out_t result,
  input logic          done
);
  import lpc_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised after transfer");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done) else $error("result missing");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    (done && result.evicted_valid) |-> !result.hit) else $error("eviction on hit");

  a_no_victim_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.evicted_valid) |-> (result.evicted_page == '0 &&
      !result.evicted_dirty)) else $error("stale victim fields");

endmodule

bind lru_page_cache_with_dirty_tracking lpc_port_checks u_lpc_port_checks (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .result (result),
  .done   (done)
);

// ===== dv/lpc_checker.sv =====
// ---------------------------------------------------------------------------
// lpc_checker
// Watches the access and result channels of the LRU page cache, predicts each
// result from its own copy of the page table, recency ranks and counters, and
// compares every field against the oldest prediction.
// ---------------------------------------------------------------------------
module lpc_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  lpc_pkg::in_t                 item,
  input  lpc_pkg::out_t                result,
  input  logic                         done,
  input  logic                         cfg_we,
  input  logic [lpc_pkg::CFG_BITS-1:0] cfg_data,
  output int                           fail_count,
  output int                           pending,
  output int                           result_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import lpc_pkg::*;

  logic [31:0]         page_tag [CAPACITY];
  logic                page_live [CAPACITY];
  logic                page_dirty [CAPACITY];
  int unsigned         page_rank [CAPACITY];
  int unsigned         live_count;
  logic [31:0]         totals [NUM_CNT];
  logic [CFG_BITS-1:0] capacity_reg;
  out_t                expected_results [$];

  function automatic logic [31:0] sat_bump(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  task automatic predict_access(in_t acc);
    out_t        r;
    int          cap;
    int          found;
    int          slot;
    int unsigned oldest;
    int unsigned a;
    logic        rd;
    r = '0;
    rd = (acc.mode == MODE_READ);
    cap = capacity_reg;
    found = -1;
    slot = -1;
    oldest = 0;
    if (cap < 1) cap = 1;
    if (cap > CAPACITY) cap = CAPACITY;
    totals[CNT_REQ] = sat_bump(totals[CNT_REQ]);
    if (!rd) begin
      totals[CNT_WR] = sat_bump(totals[CNT_WR]);
      totals[CNT_WT_EVICT] = sat_bump(totals[CNT_WT_EVICT]);
    end
    for (int i = 0; i < CAPACITY; i++)
      if (found < 0 && page_live[i] && page_tag[i] == acc.page_number) found = i;
    if (found >= 0) begin
      a = page_rank[found];
      totals[CNT_HIT] = sat_bump(totals[CNT_HIT]);
      if (rd) totals[CNT_RD] = sat_bump(totals[CNT_RD]);
      for (int i = 0; i < CAPACITY; i++)
        if (page_live[i] && page_rank[i] < a) page_rank[i]++;
      page_rank[found] = 0;
      if (!rd) page_dirty[found] = 1'b1;
      r.hit = 1'b1;
    end else begin
      if (live_count >= cap && live_count > 0) begin
        for (int i = 0; i < CAPACITY; i++)
          if (page_live[i] && (slot < 0 || page_rank[i] > oldest)) begin
            slot = i;
            oldest = page_rank[i];
          end
        r.evicted_valid = 1'b1;
        r.evicted_page = page_tag[slot];
        r.evicted_dirty = page_dirty[slot];
        page_live[slot] = 1'b0;
        live_count--;
        if (r.evicted_dirty) totals[CNT_WB_EVICT] = sat_bump(totals[CNT_WB_EVICT]);
      end else begin
        for (int i = 0; i < CAPACITY; i++)
          if (slot < 0 && !page_live[i]) slot = i;
      end
      if (rd) begin
        totals[CNT_WB_ADMIT] = sat_bump(totals[CNT_WB_ADMIT]);
        totals[CNT_WT_ADMIT] = sat_bump(totals[CNT_WT_ADMIT]);
      end
      if (slot >= 0) begin
        for (int i = 0; i < CAPACITY; i++)
          if (page_live[i]) page_rank[i]++;
        page_tag[slot] = acc.page_number;
        page_live[slot] = 1'b1;
        page_dirty[slot] = !rd;
        page_rank[slot] = 0;
        live_count++;
      end
    end
    r.hit_total = totals[CNT_HIT];
    r.request_total = totals[CNT_REQ];
    r.wb_admit_total = totals[CNT_WB_ADMIT];
    r.wb_evict_total = totals[CNT_WB_EVICT];
    r.wt_admit_total = totals[CNT_WT_ADMIT];
    r.wt_evict_total = totals[CNT_WT_EVICT];
    r.cache_read_total = totals[CNT_RD];
    r.cache_write_total = totals[CNT_WR];
    expected_results.push_back(r);
  endtask

  task automatic report(string name, logic [31:0] exp_v, logic [31:0] act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on result %0d, %s: expected %h, got %h",
               result_count, name, exp_v, act_v);
  endtask

  task automatic check_result(out_t got);
    out_t e;
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result transfer");
      return;
    end
    e = expected_results.pop_front();
    if (got.hit !== e.hit) report("hit", e.hit, got.hit);
    if (got.evicted_valid !== e.evicted_valid)
      report("evicted_valid", e.evicted_valid, got.evicted_valid);
    if (got.evicted_page !== e.evicted_page)
      report("evicted_page", e.evicted_page, got.evicted_page);
    if (got.evicted_dirty !== e.evicted_dirty)
      report("evicted_dirty", e.evicted_dirty, got.evicted_dirty);
    if (got.hit_total !== e.hit_total) report("hit_total", e.hit_total, got.hit_total);
    if (got.request_total !== e.request_total)
      report("request_total", e.request_total, got.request_total);
    if (got.wb_admit_total !== e.wb_admit_total)
      report("wb_admit_total", e.wb_admit_total, got.wb_admit_total);
    if (got.wb_evict_total !== e.wb_evict_total)
      report("wb_evict_total", e.wb_evict_total, got.wb_evict_total);
    if (got.wt_admit_total !== e.wt_admit_total)
      report("wt_admit_total", e.wt_admit_total, got.wt_admit_total);
    if (got.wt_evict_total !== e.wt_evict_total)
      report("wt_evict_total", e.wt_evict_total, got.wt_evict_total);
    if (got.cache_read_total !== e.cache_read_total)
      report("cache_read_total", e.cache_read_total, got.cache_read_total);
    if (got.cache_write_total !== e.cache_write_total)
      report("cache_write_total", e.cache_write_total, got.cache_write_total);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) begin
        page_tag[i] = '0;
        page_live[i] = 1'b0;
        page_dirty[i] = 1'b0;
        page_rank[i] = 0;
      end
      for (int k = 0; k < NUM_CNT; k++) totals[k] = '0;
      live_count = 0;
      capacity_reg = CAP_RESET;
      expected_results.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (done === 1'b1) begin
        check_result(result);
        result_count++;
      end
      if (cfg_we === 1'b1) capacity_reg = cfg_data;
      if (start === 1'b1 && busy === 1'b0) predict_access(item);
    end
    pending = expected_results.size();
  end
endmodule

// ===== dv/tb_lru_page_cache_with_dirty_tracking.sv =====
// ---------------------------------------------------------------------------
// tb_lru_page_cache_with_dirty_tracking
// Drives page accesses and capacity writes into the LRU page cache: a short
// directed sequence, then random working sets at several capacities.
// ---------------------------------------------------------------------------
module tb_lru_page_cache_with_dirty_tracking;
  timeunit 1ns;
  timeprecision 1ps;
  import lpc_pkg::*;

  localparam int LIMIT = 400000;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  in_t                 item;
  out_t                result;
  logic                done;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_data;
  int                  fail_count;
  int                  pending;
  int                  result_count;
  int                  cycle_count;
  int                  access_count;
  int                  phase_count;
  logic [31:0]         working_set [16];

  lru_page_cache_with_dirty_tracking i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .result   (result),
    .done     (done),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  lpc_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result       (result),
    .done         (done),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("lru_page_cache_with_dirty_tracking verification failed");
      $finish;
    end
  end

  task automatic random_gap();
    int n;
    n = $urandom_range(0, 9);
    if (n >= 7) n = $urandom_range(0, 2);
    else if (n == 6) n = $urandom_range(5, 25);
    else n = 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic do_access(logic [31:0] pg, logic md);
    start <= 1'b1;
    item.page_number <= pg;
    item.mode <= md;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    start <= 1'b0;
    @(posedge clk);
    access_count++;
    random_gap();
  endtask

  task automatic write_capacity(logic [CFG_BITS-1:0] v);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    phase_count++;
  endtask

  task automatic random_phase(int n, int span);
    int          k;
    logic [31:0] pg;
    for (int i = 0; i < 16; i++) working_set[i] = $urandom();
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 15);
      if (k < 13) pg = working_set[$urandom_range(0, span - 1)];
      else if (k < 15) pg = $urandom_range(0, 3);
      else pg = $urandom();
      do_access(pg, 1'($urandom()));
    end
  endtask

  initial begin
    logic [CFG_BITS-1:0] caps [8];
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    cycle_count = 0;
    access_count = 0;
    phase_count = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    do_access(32'h0000_0000, MODE_READ);
    do_access(32'hFFFF_FFFF, ~MODE_READ);
    do_access(32'h0000_0000, ~MODE_READ);
    do_access(32'hFFFF_FFFF, MODE_READ);
    do_access(32'hAAAA_AAAA, MODE_READ);
    do_access(32'h5555_5555, ~MODE_READ);
    write_capacity(7'd2);
    do_access(32'h0000_0001, MODE_READ);
    do_access(32'h0000_0002, ~MODE_READ);
    do_access(32'h5555_5555, MODE_READ);
    do_access(32'h0000_0003, MODE_READ);
    write_capacity(7'd0);
    do_access(32'h0000_0004, ~MODE_READ);
    do_access(32'h0000_0004, MODE_READ);
    do_access(32'h0000_0005, MODE_READ);
    write_capacity(7'd127);
    for (int i = 0; i < 8; i++) do_access(32'h100 + i, 1'(i));

    caps = '{7'd1, 7'd3, 7'd8, 7'd64, 7'd2, 7'd100, 7'd5, 7'd12};
    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      random_phase(225, (p == 3) ? 16 : $urandom_range(2, 16));
    end

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("%0d accesses in %0d capacity phases, %0d results checked",
             access_count, phase_count, result_count);
    if (fail_count == 0) begin
      $display("lru_page_cache_with_dirty_tracking verification clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("lru_page_cache_with_dirty_tracking verification failed");
    end
    $finish;
  end
endmodule
